// ----- hdl/stp_pkg.sv -----
`timescale 1ns / 1ps

package stp_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    localparam int MS_W     = 32;
    localparam int WEIGHT_W = 22;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [WEIGHT_W-1:0] W_HOURS   = 22'd3600000;
    localparam logic [WEIGHT_W-1:0] W_MINUTES = 22'd60000;
    localparam logic [WEIGHT_W-1:0] W_SECONDS = 22'd1000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HOURS   = 3'd1,
        PH_MINUTES = 3'd2,
        PH_SECONDS = 3'd3,
        PH_MILLIS  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_TOOLONG = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        logic              emit;
        logic [MS_W-1:0]   millis_total;
        t_status           status;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [WEIGHT_W-1:0] field_weight(input t_phase ph);
        logic [WEIGHT_W-1:0] w;
        unique case (ph)
            PH_HOURS:   w = W_HOURS;
            PH_MINUTES: w = W_MINUTES;
            PH_SECONDS: w = W_SECONDS;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/stp_core.sv -----
`timescale 1ns / 1ps

module stp_core #(
    parameter int MAX_DIGITS = stp_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_start,
    input  logic [7:0]                  i_ch,
    output stp_pkg::t_result            o_res
);
    import stp_pkg::*;

    localparam int FV_W  = $clog2(10 ** MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    t_phase                 r_phase, n_phase;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [FV_W-1:0]        r_fval, n_fval;
    logic [MS_W-1:0]        r_total;
    logic [MS_W-1:0]        r_pend;

    logic                   dig, term, clr, load;
    logic [7:0]             delim;
    logic [FV_W+3:0]        acc;
    logic [FV_W+WEIGHT_W-1:0] prod;
    t_result                res;

    assign dig   = is_digit(i_ch);
    assign term  = (i_ch == CH_NUL) || is_space(i_ch);
    assign delim = (r_phase == PH_SECONDS) ? CH_COMMA : CH_COLON;
    assign acc   = ({4'd0, r_fval} << 3) + ({4'd0, r_fval} << 1)
                 + {FV_W'(0), i_ch[3:0]};
    assign prod  = {WEIGHT_W'(0), r_fval} * {FV_W'(0), field_weight(r_phase)};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_start) begin
            n_phase = dig ? PH_HOURS : PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_HOURS, PH_MINUTES, PH_SECONDS: begin
                    if (dig) begin
                        if (r_cnt >= CNT_W'(MAX_DIGITS)) n_phase = PH_IDLE;
                    end else if (i_ch != delim || r_cnt == '0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = t_phase'(r_phase + 3'd1);
                    end
                end
                PH_MILLIS: begin
                    if (!dig || r_cnt >= CNT_W'(MAX_DIGITS)) n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // field update and result
    always_comb begin
        n_cnt            = r_cnt;
        n_fval           = r_fval;
        clr              = 1'b0;
        load             = 1'b0;
        res.emit         = 1'b0;
        res.millis_total = '0;
        res.status       = ST_OK;
        if (i_start) begin
            clr = 1'b1;
            if (dig) begin
                n_cnt  = CNT_W'(1);
                n_fval = FV_W'(i_ch[3:0]);
            end else begin
                res.emit   = 1'b1;
                res.status = ST_BADCHAR;
            end
        end else if (r_phase == PH_IDLE || r_phase > PH_MILLIS) begin
            n_cnt = r_cnt;
        end else if (dig) begin
            if (r_cnt >= CNT_W'(MAX_DIGITS)) begin
                clr        = 1'b1;
                res.emit   = 1'b1;
                res.status = ST_TOOLONG;
            end else begin
                n_fval = acc[FV_W-1:0];
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end else if (r_phase == PH_MILLIS) begin
            clr      = 1'b1;
            res.emit = 1'b1;
            if (!term) begin
                res.status = ST_BADCHAR;
            end else if (r_cnt == '0) begin
                res.status = ST_EMPTY;
            end else begin
                res.millis_total = r_total + MS_W'(r_fval);
            end
        end else if (i_ch != delim) begin
            clr        = 1'b1;
            res.emit   = 1'b1;
            res.status = ST_BADCHAR;
        end else if (r_cnt == '0) begin
            clr        = 1'b1;
            res.emit   = 1'b1;
            res.status = ST_EMPTY;
        end else begin
            load   = 1'b1;
            n_fval = '0;
            n_cnt  = '0;
        end
        if (clr && !i_start) begin
            n_cnt  = '0;
            n_fval = '0;
        end
    end

    // weighted field product is parked in r_pend and folded into the total
    // on the following cycle; a field always needs a digit before the next use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_fval  <= '0;
            r_total <= '0;
            r_pend  <= '0;
        end else begin
            if (i_fire) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_fval  <= n_fval;
            end
            if (i_fire && clr) begin
                r_total <= '0;
                r_pend  <= '0;
            end else begin
                r_total <= r_total + r_pend;
                r_pend  <= (i_fire && load) ? MS_W'(prod) : '0;
            end
        end
    end

    assign o_res = res;

endmodule

// ----- hdl/subtitle_timestamp_parser.sv -----
`timescale 1ns / 1ps

// Timestamp parser for text of the form hh:mm:ss,mmm.
// Slave side: one character per word, i_s_tdata holds the ASCII byte and
// i_s_tuser marks the first character of a new timestamp.
// Master side: one word per finished timestamp or per first error;
// o_m_tdata carries the millisecond total (zero on error) and o_m_tuser
// the status (ok, bad character, field too long, empty field).
// A word accepted into the input register is parsed there; its result, if
// any, is registered onto the master side when the word is consumed.
// One character per cycle is taken sustained while results are taken: an input
// register and an output register bracket a single pass of compare,
// decimal accumulate and one constant-weight multiply per field.
// When the master side stalls with a result held, the input register
// still fills, then o_s_tready drops until the result is taken.
// Reset (synchronous, active low) empties both registers and returns
// the parser to idle, waiting for a start character.
module subtitle_timestamp_parser #(
    parameter int MAX_DIGITS = stp_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tuser,   // [0] start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] millis_total
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import stp_pkg::*;

    logic       r_in_valid;
    logic       r_in_start;
    logic [7:0] r_in_ch;
    logic       r_out_valid;
    logic [MS_W-1:0] r_out_ms;
    t_status    r_out_st;
    logic       fire;
    t_result    res;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    stp_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_start (r_in_start),
        .i_ch    (r_in_ch),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_start <= i_s_tuser;
            r_in_ch    <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res.emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.emit) begin
            r_out_ms <= res.millis_total;
            r_out_st <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_ms;
    assign o_m_tuser  = r_out_st;

endmodule

// ----- dv/subtitle_timestamp_parser_test.sv -----
`timescale 1ns / 1ps

module subtitle_timestamp_parser_test;

    import stp_pkg::*;

    localparam int MAX_DIG     = MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PER_PHASE   = 360;
    localparam int SETTLE      = 4;

    class stamp_scoreboard;
        t_phase          phase;
        int unsigned     ndig;
        logic [31:0]     fval;
        logic [31:0]     acc;
        logic [31:0]     want_ms[$];
        t_status         want_st[$];
        int unsigned     errors;
        int unsigned     live_words;

        function new();
            phase      = PH_IDLE;
            ndig       = 0;
            fval       = '0;
            acc        = '0;
            errors     = 0;
            live_words = 0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void emit(logic [31:0] ms, t_status st);
            want_ms.push_back(ms);
            want_st.push_back(st);
            phase = PH_IDLE;
            ndig  = 0;
            fval  = '0;
            acc   = '0;
        endfunction

        function void note_input(logic start, logic [7:0] c);
            logic [7:0]  delim;
            logic [31:0] weight;
            if (start) begin
                live_words++;
                if (!is_dec(c)) begin
                    emit('0, ST_BADCHAR);
                    return;
                end
                phase = PH_HOURS;
                ndig  = 1;
                fval  = 32'(c - CH_ZERO);
                acc   = '0;
                return;
            end
            if (phase == PH_IDLE)
                return;
            live_words++;
            if (is_dec(c)) begin
                if (ndig >= MAX_DIG) begin
                    emit('0, ST_TOOLONG);
                    return;
                end
                fval = fval * 10 + 32'(c - CH_ZERO);
                ndig++;
                return;
            end
            if (phase == PH_MILLIS) begin
                if (c == CH_NUL || is_ws(c)) begin
                    if (ndig == 0)
                        emit('0, ST_EMPTY);
                    else
                        emit(acc + fval, ST_OK);
                end else begin
                    emit('0, ST_BADCHAR);
                end
                return;
            end
            delim = (phase == PH_SECONDS) ? CH_COMMA : CH_COLON;
            if (c != delim) begin
                emit('0, ST_BADCHAR);
                return;
            end
            if (ndig == 0) begin
                emit('0, ST_EMPTY);
                return;
            end
            case (phase)
                PH_HOURS: begin
                    weight = 32'(W_HOURS);
                    phase  = PH_MINUTES;
                end
                PH_MINUTES: begin
                    weight = 32'(W_MINUTES);
                    phase  = PH_SECONDS;
                end
                default: begin
                    weight = 32'(W_SECONDS);
                    phase  = PH_MILLIS;
                end
            endcase
            acc  = acc + fval * weight;
            fval = '0;
            ndig = 0;
        endfunction

        function void check_result(logic [31:0] ms, logic [1:0] st);
            logic [31:0] wms;
            t_status     wst;
            if (want_ms.size() == 0) begin
                errors++;
                $display("%0t: unexpected word ms=%0d status=%0d", $time, ms, st);
                return;
            end
            wms = want_ms.pop_front();
            wst = want_st.pop_front();
            if (ms !== wms) begin
                errors++;
                $display("%0t: millis_total expected %0d actual %0d", $time, wms, ms);
            end
            if (st !== 2'(wst)) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, wst, st);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned cyc;

    stamp_scoreboard sb = new();

    subtitle_timestamp_parser #(
        .MAX_DIGITS(MAX_DIG)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_input(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser);
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_word(input logic start, input logic [7:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = start;
        i_s_tdata  = c;
        forever begin
            @(posedge i_clk);
            if (o_s_tready)
                break;
        end
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(i == 0, s[i]);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (sb.want_ms.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_random_stamp();
        logic [7:0] seq[$];
        int         n;
        int         r;
        int         cut;
        int         k;
        for (int f = 0; f < 4; f++) begin
            r = $urandom_range(0, 99);
            n = (r < 5) ? 0 : (r < 10) ? MAX_DIG + 1 : $urandom_range(1, MAX_DIG);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    seq.push_back(CH_NINE);
                else
                    seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if (f < 3)
                seq.push_back(f == 2 ? CH_COMMA : CH_COLON);
        end
        k = $urandom_range(0, 6);
        seq.push_back(k == 0 ? CH_NUL : k == 1 ? CH_SPACE : CH_TAB + 8'(k - 2));
        if ($urandom_range(0, 99) < 12)
            seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
        cut = seq.size();
        if ($urandom_range(0, 99) < 5)
            cut = $urandom_range(1, seq.size());
        for (int i = 0; i < cut; i++)
            send_word(i == 0, seq[i]);
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3))
                send_word($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned goal;
        goal = sb.live_words + count;
        while (sb.live_words < goal)
            send_random_stamp();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tuser    = 1'b0;
        i_s_tdata    = '0;
        src_idle_pct = 14;
        snk_idle_pct = 69;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // well-formed stamps, field extremes, every terminator
        send_str("0:0:0,0");
        send_word(1'b0, CH_NUL);
        send_str("999:999:999,999");
        send_word(1'b0, CH_SPACE);
        for (int t = CH_TAB; t <= CH_CR; t++) begin
            send_str("1:2:3,4");
            send_word(1'b0, 8'(t));
        end
        // start on a non-digit, stray bytes while idle
        send_word(1'b1, CH_COLON);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h41);
        // restart while a stamp is in progress
        send_str("12:3");
        send_str("5:6:7,8");
        send_word(1'b0, CH_CR);
        // too many digits in each field
        send_str("1234");
        send_str("1:1234");
        send_str("1:1:1234");
        send_str("1:1:1,1234");
        // empty fields
        send_str("1::");
        send_str("1:1:,");
        send_str("1:1:1,");
        send_word(1'b0, CH_SPACE);
        // bad characters, wrong delimiter, early end of string
        send_str("1;");
        send_str("1:1:1:");
        send_str("1:1:1,1x");
        send_str("1:1");
        send_word(1'b0, CH_NUL);
        drain();

        run_random(PER_PHASE);
        drain();
        src_idle_pct = 69;
        snk_idle_pct = 14;
        run_random(PER_PHASE);
        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(PER_PHASE);
        drain();

        if (sb.errors == 0 && sb.want_ms.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- subtitle_timestamp_parser.f -----
hdl/stp_pkg.sv
hdl/stp_core.sv
hdl/subtitle_timestamp_parser.sv
dv/subtitle_timestamp_parser_test.sv
